### hw/rtl/tlpw_pkg.sv
`timescale 1ns / 1ps

package tlpw_pkg;

   // Address geometry: 128 pages of 32 bytes, 15-bit virtual address
   localparam int PAGE_W       = 7;
   localparam int OFFSET_W     = 5;
   localparam int INDEX_W      = 5;
   localparam int VADDR_W      = 15;
   localparam int BYTE_W       = 8;
   localparam int KIND_W       = 2;
   localparam int STORE_ADDR_W = PAGE_W + OFFSET_W;
   localparam int STORE_DEPTH  = 1 << STORE_ADDR_W;

   // Virtual address field positions
   localparam int DIR_IDX_LSB = OFFSET_W + INDEX_W;
   localparam int TAB_IDX_LSB = OFFSET_W;

   // Entry encoding
   localparam int PRESENT_BIT = 7;

   typedef logic [PAGE_W-1:0]       page_type;
   typedef logic [OFFSET_W-1:0]     offset_type;
   typedef logic [BYTE_W-1:0]       byte_type;
   typedef logic [STORE_ADDR_W-1:0] store_addr_type;

   localparam page_type DIR_PAGE_RESET = 7'h6c;
   localparam byte_type NOT_MAPPED     = 8'h7f;

   // Item kinds on the request channel; the fourth code is ignored
   typedef enum logic [KIND_W-1:0] {
      KIND_TRANSLATE  = 2'd0,
      KIND_WRITE_MEM  = 2'd1,
      KIND_WRITE_DISK = 2'd2
   } kind_type;

   // One store write
   typedef struct packed {
      logic           en;
      store_addr_type addr;
      byte_type       data;
   } wr_cmd_type;

   // Bypass of a not yet committed memory write to the directory read
   typedef struct packed {
      logic     hit;
      byte_type data;
   } fwd_type;

   // Byte index of a page and an offset within it
   function automatic store_addr_type store_index(page_type page, offset_type offset);
      return {page, offset};
   endfunction

endpackage

### hw/rtl/tlpw_req_if.sv
`timescale 1ns / 1ps

interface tlpw_req_if;
   logic                         valid;
   logic                         ready;
   logic [tlpw_pkg::KIND_W-1:0]  kind;
   logic [tlpw_pkg::VADDR_W-1:0] address;
   logic [tlpw_pkg::BYTE_W-1:0]  data;

   modport source (output valid, output kind, output address, output data, input ready);
   modport sink   (input valid, input kind, input address, input data, output ready);
endinterface

### hw/rtl/tlpw_rsp_if.sv
`timescale 1ns / 1ps

interface tlpw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        fault;
   logic                        on_disk;
   logic [tlpw_pkg::PAGE_W-1:0] frame;
   logic [tlpw_pkg::BYTE_W-1:0] value;

   modport source (output valid, output fault, output on_disk, output frame, output value,
                   input ready);
   modport sink   (input valid, input fault, input on_disk, input frame, input value,
                   output ready);
endinterface

### hw/rtl/two_level_page_walk.sv
`timescale 1ns / 1ps
// A translate beat passes through stage registers s1, s2 and s3; s3 drives its response beat.
// Throughput: one beat per cycle; three dependent memory reads (directory, table, frame)
// each take one stage on the synchronous stores, and the whole pipe holds while rsp stalls.
// Write beats produce no response and commit one pipeline step after acceptance.
// Reset: synchronous, clears the pipe and sets directory_page to 108; stores are not cleared.
module two_level_page_walk (
   input  logic                      clock,
   input  logic                      reset,
   tlpw_req_if.sink                  req_ch,
   tlpw_rsp_if.source                rsp_ch,
   input  logic                      csr_write_enable,
   input  logic [tlpw_pkg::PAGE_W-1:0] csr_write_data
);
   import tlpw_pkg::*;

   page_type       directory_page_ff;
   logic           advance;
   logic           req_accept;
   logic           is_translate;
   store_addr_type dir_addr;
   store_addr_type wr_addr;
   wr_cmd_type     mem_wr;
   wr_cmd_type     disk_wr;
   fwd_type        fwd;

   // Stage 1: directory entry in flight
   logic           s1_valid_ff, s1_valid_in;
   offset_type     s1_tab_idx_ff;
   offset_type     s1_offset_ff;
   fwd_type        s1_fwd_ff;
   // Stage 2: table entry in flight
   logic           s2_valid_ff, s2_valid_in;
   logic           s2_fault_ff, s2_fault_in;
   offset_type     s2_offset_ff;
   // Stage 3: data byte in flight, doubles as the response register
   logic           s3_valid_ff, s3_valid_in;
   logic           s3_fault_ff, s3_fault_in;
   logic           s3_disk_ff, s3_disk_in;
   page_type       s3_frame_ff, s3_frame_in;

   byte_type       dir_rd_data;
   byte_type       tab_rd_data;
   byte_type       mem_rd_data;
   byte_type       disk_rd_data;
   byte_type       dir_entry;
   store_addr_type tab_addr;
   store_addr_type frame_addr;

   // Control register
   always_ff @(posedge clock) begin
      if (reset) begin
         directory_page_ff <= DIR_PAGE_RESET;
      end else if (csr_write_enable) begin
         directory_page_ff <= csr_write_data;
      end
   end

   // Handshake: the pipe moves whenever the response slot is free or being taken;
   // no request beat is taken in reset
   assign advance      = !s3_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance && !reset;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign is_translate = req_accept && (req_ch.kind == KIND_TRANSLATE);

   assign dir_addr = store_index(directory_page_ff,
                                 req_ch.address[DIR_IDX_LSB +: INDEX_W]);
   assign wr_addr  = req_ch.address[STORE_ADDR_W-1:0];

   tlpw_write_buf u_write_buf (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .accept  (req_accept),
      .kind    (req_ch.kind),
      .wr_addr (wr_addr),
      .wr_data (req_ch.data),
      .dir_addr(dir_addr),
      .mem_wr  (mem_wr),
      .disk_wr (disk_wr),
      .fwd     (fwd)
   );

   // Stage 1 -> 2: resolve directory entry, address the table
   assign dir_entry = s1_fwd_ff.hit ? s1_fwd_ff.data : dir_rd_data;
   assign tab_addr  = store_index(dir_entry[PAGE_W-1:0], s1_tab_idx_ff);

   // Memory copy for the walk: directory and table reads
   tlpw_ram_2r u_walk_ram (
      .clock    (clock),
      .rd_en    (advance),
      .rd_addr_a(dir_addr),
      .rd_addr_b(tab_addr),
      .wr       (mem_wr),
      .rd_data_a(dir_rd_data),
      .rd_data_b(tab_rd_data)
   );

   // Stage 2 -> 3: decode table entry, address the frame byte
   always_comb begin
      s3_fault_in = s2_fault_ff || (tab_rd_data == NOT_MAPPED);
      s3_disk_in  = !tab_rd_data[PRESENT_BIT];
      s3_frame_in = tab_rd_data[PAGE_W-1:0];
   end
   assign frame_addr = store_index(s3_frame_in, s2_offset_ff);

   // Memory copy for the final byte read
   tlpw_ram_1r u_data_ram (
      .clock  (clock),
      .rd_en  (advance),
      .rd_addr(frame_addr),
      .wr     (mem_wr),
      .rd_data(mem_rd_data)
   );

   tlpw_ram_1r u_disk_ram (
      .clock  (clock),
      .rd_en  (advance),
      .rd_addr(frame_addr),
      .wr     (disk_wr),
      .rd_data(disk_rd_data)
   );

   // Pipe valids
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      s3_valid_in = s3_valid_ff;
      s2_fault_in = !dir_entry[PRESENT_BIT];
      if (advance) begin
         s1_valid_in = is_translate;
         s2_valid_in = s1_valid_ff;
         s3_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tab_idx_ff <= req_ch.address[TAB_IDX_LSB +: INDEX_W];
         s1_offset_ff  <= req_ch.address[OFFSET_W-1:0];
         s1_fwd_ff     <= fwd;
         s2_fault_ff   <= s2_fault_in;
         s2_offset_ff  <= s1_offset_ff;
         s3_fault_ff   <= s3_fault_in;
         s3_disk_ff    <= s3_disk_in;
         s3_frame_ff   <= s3_frame_in;
      end
   end

   // Response beat; a fault zeroes the other fields
   always_comb begin
      rsp_ch.valid   = s3_valid_ff;
      rsp_ch.fault   = s3_fault_ff;
      rsp_ch.on_disk = !s3_fault_ff && s3_disk_ff;
      rsp_ch.frame   = s3_fault_ff ? '0 : s3_frame_ff;
      rsp_ch.value   = '0;
      if (!s3_fault_ff) begin
         rsp_ch.value = s3_disk_ff ? disk_rd_data : mem_rd_data;
      end
   end

endmodule

### hw/rtl/tlpw_ram_2r.sv
`timescale 1ns / 1ps

module tlpw_ram_2r (
   input  logic                     clock,
   input  logic                     rd_en,
   input  tlpw_pkg::store_addr_type rd_addr_a,
   input  tlpw_pkg::store_addr_type rd_addr_b,
   input  tlpw_pkg::wr_cmd_type     wr,
   output tlpw_pkg::byte_type       rd_data_a,
   output tlpw_pkg::byte_type       rd_data_b
);
   import tlpw_pkg::*;

   byte_type mem [STORE_DEPTH];
   byte_type rd_data_a_ff;
   byte_type rd_data_b_ff;

   // One write port, two registered read ports, read-before-write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### hw/rtl/tlpw_ram_1r.sv
`timescale 1ns / 1ps

module tlpw_ram_1r (
   input  logic                     clock,
   input  logic                     rd_en,
   input  tlpw_pkg::store_addr_type rd_addr,
   input  tlpw_pkg::wr_cmd_type     wr,
   output tlpw_pkg::byte_type       rd_data
);
   import tlpw_pkg::*;

   byte_type mem [STORE_DEPTH];
   byte_type rd_data_ff;

   // One write port, one registered read port, read-before-write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tlpw_write_buf.sv
`timescale 1ns / 1ps

module tlpw_write_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     accept,
   input  logic [tlpw_pkg::KIND_W-1:0] kind,
   input  tlpw_pkg::store_addr_type wr_addr,
   input  tlpw_pkg::byte_type       wr_data,
   input  tlpw_pkg::store_addr_type dir_addr,
   output tlpw_pkg::wr_cmd_type     mem_wr,
   output tlpw_pkg::wr_cmd_type     disk_wr,
   output tlpw_pkg::fwd_type        fwd
);
   import tlpw_pkg::*;

   logic           pend_valid_ff, pend_valid_in;
   logic           pend_disk_ff, pend_disk_in;
   store_addr_type pend_addr_ff, pend_addr_in;
   byte_type       pend_data_ff, pend_data_in;
   logic           is_write;

   // A write beat is held one pipeline step so that older walks still read old data
   always_comb begin
      is_write      = accept && (kind == KIND_WRITE_MEM || kind == KIND_WRITE_DISK);
      pend_valid_in = pend_valid_ff;
      pend_disk_in  = pend_disk_ff;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      if (advance) begin
         pend_valid_in = is_write;
         pend_disk_in  = (kind == KIND_WRITE_DISK);
         pend_addr_in  = wr_addr;
         pend_data_in  = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      pend_disk_ff <= pend_disk_in;
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
   end

   // Commit on the next pipeline step
   always_comb begin
      mem_wr.en    = advance && pend_valid_ff && !pend_disk_ff;
      mem_wr.addr  = pend_addr_ff;
      mem_wr.data  = pend_data_ff;
      disk_wr.en   = advance && pend_valid_ff && pend_disk_ff;
      disk_wr.addr = pend_addr_ff;
      disk_wr.data = pend_data_ff;
   end

   // The directory read issued at the commit edge misses the write: bypass it
   always_comb begin
      fwd.hit  = pend_valid_ff && !pend_disk_ff && (pend_addr_ff == dir_addr);
      fwd.data = pend_data_ff;
   end

endmodule
